// File: design/dsmpwm_pkg.sv
// Shared types and constants for the three-channel delta-sigma PWM dither block.
// No dependencies; imported by the lane, merge and top-level modules.
package dsmpwm_pkg;

    // Default fixed-point split of a channel level
    localparam int FRACTION_BITS_DEF = 7;
    localparam int DUTY_BITS_DEF     = 8;
    localparam int NUM_LANES         = 3;

    // Request opcodes; the fourth code is unused and changes nothing
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SET  = 2'd1,
        OP_OFF  = 2'd2
    } op_t;

    // Per-request strobes from the decoder to every lane
    typedef struct packed {
        logic tick;
        logic set;
        logic clear;
    } lane_ctrl_t;

    // Shared status bits carried next to the lane results
    typedef struct packed {
        logic counter_reset;
        logic dither_on;
    } status_t;

endpackage

// File: design/dsmpwm_lane.sv
// One channel of the dither core: level store, fraction accumulator, duty pipeline.
// Depends on dsmpwm_pkg (lane_ctrl_t).
module dsmpwm_lane #(
    parameter int FRACTION_BITS = dsmpwm_pkg::FRACTION_BITS_DEF,
    parameter int DUTY_BITS     = dsmpwm_pkg::DUTY_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dsmpwm_pkg::lane_ctrl_t            ctrl,
    input  logic [DUTY_BITS+FRACTION_BITS-1:0] level,
    input  logic                              force_on,
    output logic [DUTY_BITS-1:0]              duty_next,
    output logic                              power_next
);
    import dsmpwm_pkg::*;

    localparam int LevelBits = DUTY_BITS + FRACTION_BITS;

    logic [LevelBits-1:0]     target_reg,  target_next;
    logic [FRACTION_BITS-1:0] accum_reg,   accum_next;
    logic [DUTY_BITS-1:0]     pending_reg, pending_next;
    logic [DUTY_BITS-1:0]     current_reg, current_next;
    logic                     power_reg,   power_next_int;

    logic [LevelBits-1:0]     level_sat;
    logic                     level_over;
    logic [FRACTION_BITS:0]   frac_sum;

    // Saturate: integer part all ones with a nonzero fraction is above the maximum
    assign level_over = (&level[LevelBits-1:FRACTION_BITS]) && (|level[FRACTION_BITS-1:0]);
    assign level_sat  = level_over ? {level[LevelBits-1:FRACTION_BITS], {FRACTION_BITS{1'b0}}}
                                   : level;

    // First-order delta-sigma: fraction plus accumulator, carry bumps the duty
    assign frac_sum = {1'b0, accum_reg} + {1'b0, target_reg[FRACTION_BITS-1:0]};

    // Next-state selection for this channel
    always_comb begin
        target_next    = target_reg;
        accum_next     = accum_reg;
        pending_next   = pending_reg;
        current_next   = current_reg;
        power_next_int = power_reg;
        priority if (ctrl.set) begin
            target_next    = level_sat;
            pending_next   = level_sat[LevelBits-1:FRACTION_BITS];
            current_next   = level_sat[LevelBits-1:FRACTION_BITS];
            power_next_int = (|level_sat) || force_on;
        end else if (ctrl.clear) begin
            target_next    = '0;
            pending_next   = '0;
            current_next   = '0;
            power_next_int = 1'b0;
        end else if (ctrl.tick) begin
            current_next = pending_reg;
            pending_next = target_reg[LevelBits-1:FRACTION_BITS]
                         + {{(DUTY_BITS-1){1'b0}}, frac_sum[FRACTION_BITS]};
            accum_next   = frac_sum[FRACTION_BITS-1:0];
        end
    end

    // Channel state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= '0;
            accum_reg   <= '0;
            pending_reg <= '0;
            current_reg <= '0;
            power_reg   <= 1'b0;
        end else begin
            target_reg  <= target_next;
            accum_reg   <= accum_next;
            pending_reg <= pending_next;
            current_reg <= current_next;
            power_reg   <= power_next_int;
        end
    end

    // Result of this request: state after the update
    assign duty_next  = current_next;
    assign power_next = power_next_int;

endmodule

// File: design/dsmpwm_merge.sv
// Merging stage: gathers the lane results and status into one response,
// held in an output register with a skid register behind it. Depends on dsmpwm_pkg.
module dsmpwm_merge #(
    parameter int DUTY_BITS = dsmpwm_pkg::DUTY_BITS_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              in_valid,
    input  logic [dsmpwm_pkg::NUM_LANES-1:0][DUTY_BITS-1:0]   duty_in,
    input  logic [dsmpwm_pkg::NUM_LANES-1:0]                  power_in,
    input  dsmpwm_pkg::status_t                               status_in,
    output logic                                              in_ready,
    input  logic                                              m_ready,
    output logic                                              m_valid,
    output logic [dsmpwm_pkg::NUM_LANES-1:0][DUTY_BITS-1:0]   m_duty,
    output logic [dsmpwm_pkg::NUM_LANES-1:0]                  m_power,
    output dsmpwm_pkg::status_t                               m_status
);
    import dsmpwm_pkg::*;

    logic                                 out_valid_reg,  out_valid_next;
    logic [NUM_LANES-1:0][DUTY_BITS-1:0]  out_duty_reg,   out_duty_next;
    logic [NUM_LANES-1:0]                 out_power_reg,  out_power_next;
    status_t                              out_status_reg, out_status_next;
    logic                                 skid_valid_reg, skid_valid_next;
    logic [NUM_LANES-1:0][DUTY_BITS-1:0]  skid_duty_reg,  skid_duty_next;
    logic [NUM_LANES-1:0]                 skid_power_reg, skid_power_next;
    status_t                              skid_status_reg, skid_status_next;

    // Take a request whenever the skid slot is free
    assign in_ready = !skid_valid_reg;

    // Output and skid slot bookkeeping
    always_comb begin
        out_valid_next   = out_valid_reg;
        out_duty_next    = out_duty_reg;
        out_power_next   = out_power_reg;
        out_status_next  = out_status_reg;
        skid_valid_next  = skid_valid_reg;
        skid_duty_next   = skid_duty_reg;
        skid_power_next  = skid_power_reg;
        skid_status_next = skid_status_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next  = skid_valid_reg;
            out_duty_next   = skid_duty_reg;
            out_power_next  = skid_power_reg;
            out_status_next = skid_status_reg;
            skid_valid_next = 1'b0;
        end
        if (in_valid) begin
            if (!out_valid_next) begin
                out_valid_next  = 1'b1;
                out_duty_next   = duty_in;
                out_power_next  = power_in;
                out_status_next = status_in;
            end else begin
                skid_valid_next  = 1'b1;
                skid_duty_next   = duty_in;
                skid_power_next  = power_in;
                skid_status_next = status_in;
            end
        end
    end

    // Valid flags reset; payload does not need it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_duty_reg    <= out_duty_next;
        out_power_reg   <= out_power_next;
        out_status_reg  <= out_status_next;
        skid_duty_reg   <= skid_duty_next;
        skid_power_reg  <= skid_power_next;
        skid_status_reg <= skid_status_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_duty   = out_duty_reg;
    assign m_power  = out_power_reg;
    assign m_status = out_status_reg;

endmodule

// File: design/three_channel_dsm_pwm_dither_top.sv
// Top level of the three-channel delta-sigma PWM dither block.
// Depends on dsmpwm_pkg, dsmpwm_lane and dsmpwm_merge.
//
// Usage:
//   Request channel (s_*): opcode plus three levels and three force bits.
//   Opcode tick advances the dither of every channel when dithering is on,
//   set stores new levels and starts dithering, off clears all channels (accumulators kept).
//   Response channel (m_*): one response per request with the three duty
//   values, power enables, a counter_reset pulse flag and the dither state.
//   Throughput: one request per cycle while s_ready is high; the three lanes
//   update in parallel and the output or skid register takes the merged result.
//   Stall: a two-entry output stage (output register plus skid register)
//   lets one more request in while a response waits; s_ready drops only
//   when both entries are full, and responses stay in order.
//   Reset: aresetn is synchronous and active low; all levels, accumulators,
//   duty values and enables go to zero, dithering is off, no response is
//   pending.
module three_channel_dsm_pwm_dither_top #(
    parameter int FRACTION_BITS = dsmpwm_pkg::FRACTION_BITS_DEF,
    parameter int DUTY_BITS     = dsmpwm_pkg::DUTY_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_opcode,
    input  logic [DUTY_BITS+FRACTION_BITS-1:0] s_level_a,
    input  logic [DUTY_BITS+FRACTION_BITS-1:0] s_level_b,
    input  logic [DUTY_BITS+FRACTION_BITS-1:0] s_level_c,
    input  logic                               s_force_a,
    input  logic                               s_force_b,
    input  logic                               s_force_c,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [DUTY_BITS-1:0]               m_duty_a,
    output logic [DUTY_BITS-1:0]               m_duty_b,
    output logic [DUTY_BITS-1:0]               m_duty_c,
    output logic                               m_power_a,
    output logic                               m_power_b,
    output logic                               m_power_c,
    output logic                               m_counter_reset,
    output logic                               m_dither_on
);
    import dsmpwm_pkg::*;

    localparam int LevelBits = DUTY_BITS + FRACTION_BITS;

    logic                                accept;
    op_t                                 op;
    lane_ctrl_t                          ctrl;
    logic                                dither_reg, dither_next;
    status_t                             status;
    logic [NUM_LANES-1:0][LevelBits-1:0] lane_level;
    logic [NUM_LANES-1:0]                lane_force;
    logic [NUM_LANES-1:0][DUTY_BITS-1:0] lane_duty;
    logic [NUM_LANES-1:0]                lane_power;
    logic [NUM_LANES-1:0][DUTY_BITS-1:0] out_duty;
    logic [NUM_LANES-1:0]                out_power;
    status_t                             out_status;

    assign accept = s_valid && s_ready;
    assign op     = op_t'(s_opcode);

    // Opcode decode into lane strobes and the dither enable update
    always_comb begin
        ctrl                 = '0;
        dither_next          = dither_reg;
        status.counter_reset = 1'b0;
        unique case (op)
            OP_TICK: begin
                ctrl.tick = accept && dither_reg;
            end
            OP_SET: begin
                ctrl.set             = accept;
                status.counter_reset = 1'b1;
                if (accept) begin
                    dither_next = 1'b1;
                end
            end
            OP_OFF: begin
                ctrl.clear           = accept;
                status.counter_reset = 1'b1;
                if (accept) begin
                    dither_next = 1'b0;
                end
            end
            default: begin
                ctrl = '0;
            end
        endcase
        status.dither_on = dither_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_reg <= 1'b0;
        end else begin
            dither_reg <= dither_next;
        end
    end

    // Lane inputs
    assign lane_level[0] = s_level_a;
    assign lane_level[1] = s_level_b;
    assign lane_level[2] = s_level_c;
    assign lane_force[0] = s_force_a;
    assign lane_force[1] = s_force_b;
    assign lane_force[2] = s_force_c;

    // One dither lane per channel
    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        dsmpwm_lane #(
            .FRACTION_BITS (FRACTION_BITS),
            .DUTY_BITS     (DUTY_BITS)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .level      (lane_level[i]),
            .force_on   (lane_force[i]),
            .duty_next  (lane_duty[i]),
            .power_next (lane_power[i])
        );
    end

    // Merge lane results into the response register
    dsmpwm_merge #(
        .DUTY_BITS (DUTY_BITS)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .duty_in   (lane_duty),
        .power_in  (lane_power),
        .status_in (status),
        .in_ready  (s_ready),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_duty    (out_duty),
        .m_power   (out_power),
        .m_status  (out_status)
    );

    assign m_duty_a        = out_duty[0];
    assign m_duty_b        = out_duty[1];
    assign m_duty_c        = out_duty[2];
    assign m_power_a       = out_power[0];
    assign m_power_b       = out_power[1];
    assign m_power_c       = out_power[2];
    assign m_counter_reset = out_status.counter_reset;
    assign m_dither_on     = out_status.dither_on;

    // A taken set request turns dithering on
    a_set_starts_dither: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_SET) |=> dither_reg)
        else $error("dithering not started after set request");

    // A taken off request turns dithering off
    a_off_stops_dither: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == OP_OFF) |=> !dither_reg)
        else $error("dithering not stopped after off request");

    // Input side stalls only while a response is held
    a_stall_needs_response: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("request stalled with no response pending");

    // After a taken request, m_valid is always high on the next cycle
    a_accept_gives_response: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("no response after taken request");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the three-channel delta-sigma PWM dither block.
// Depends on dsmpwm_pkg and three_channel_dsm_pwm_dither_top; predicts each response in-line.
// Directed corner requests, then random set/tick/off/unused sequences with random idling on both sides.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dsmpwm_pkg::*;

    localparam int FB = FRACTION_BITS_DEF;
    localparam int DB = DUTY_BITS_DEF;
    localparam int LW = FB + DB;
    localparam logic [LW-1:0] LEVEL_MAX = LW'(((1 << DB) - 1) << FB);
    localparam logic [LW-1:0] LEVEL_TOP = '1;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1300;
    localparam int STALL_LIMIT = 1000;
    localparam int CALM_TAIL = 150;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0][LW-1:0] level;
        logic [2:0]         keep_on;
    } led_cmd_t;

    typedef struct packed {
        logic [2:0][DB-1:0] duty;
        logic [2:0]         power;
        logic               counter_reset;
        logic               dither_on;
    } led_frame_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_opcode = '0;
    logic [LW-1:0] s_level_a = '0;
    logic [LW-1:0] s_level_b = '0;
    logic [LW-1:0] s_level_c = '0;
    logic s_force_a = 1'b0;
    logic s_force_b = 1'b0;
    logic s_force_c = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [DB-1:0] m_duty_a, m_duty_b, m_duty_c;
    logic m_power_a, m_power_b, m_power_c;
    logic m_counter_reset, m_dither_on;

    three_channel_dsm_pwm_dither_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_level_a(s_level_a), .s_level_b(s_level_b), .s_level_c(s_level_c),
        .s_force_a(s_force_a), .s_force_b(s_force_b), .s_force_c(s_force_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_duty_a(m_duty_a), .m_duty_b(m_duty_b), .m_duty_c(m_duty_c),
        .m_power_a(m_power_a), .m_power_b(m_power_b), .m_power_c(m_power_c),
        .m_counter_reset(m_counter_reset), .m_dither_on(m_dither_on)
    );

    // Clock: 2 ns period
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    led_cmd_t   pending_cmds[$];
    led_frame_t due_frames[$];

    // Shadow copy of the dither state
    logic [LW-1:0] level_q    [3];
    logic [FB-1:0] frac_acc   [3];
    logic [DB-1:0] queued_duty[3];
    logic [DB-1:0] shown_duty [3];
    logic          pwr_en     [3];
    logic          dither_run;

    int reqs_issued = 0;
    int idle_stop = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    int frames_checked = 0;
    int n_set = 0, n_tick = 0, n_live_tick = 0, n_off = 0, n_unused = 0, n_sat = 0;

    // Next state and response for one request
    function automatic led_frame_t dither_step(input led_cmd_t rq);
        led_frame_t rs;
        logic [LW-1:0] lv;
        logic [FB:0] sum;
        logic pulse;
        pulse = 1'b0;
        case (rq.opcode)
            OP_TICK: begin
                if (dither_run) begin
                    n_live_tick++;
                    for (int k = 0; k < 3; k++) begin
                        shown_duty[k] = queued_duty[k];
                        sum = {1'b0, frac_acc[k]} + {1'b0, level_q[k][FB-1:0]};
                        queued_duty[k] = level_q[k][LW-1:FB] + DB'(sum[FB]);
                        frac_acc[k] = sum[FB-1:0];
                    end
                end
            end
            OP_SET: begin
                for (int k = 0; k < 3; k++) begin
                    lv = rq.level[k];
                    if (lv > LEVEL_MAX) lv = LEVEL_MAX;
                    level_q[k] = lv;
                    queued_duty[k] = lv[LW-1:FB];
                    shown_duty[k] = lv[LW-1:FB];
                    pwr_en[k] = (lv != '0) || rq.keep_on[k];
                end
                dither_run = 1'b1;
                pulse = 1'b1;
            end
            OP_OFF: begin
                // accumulators are left alone
                for (int k = 0; k < 3; k++) begin
                    level_q[k] = '0;
                    queued_duty[k] = '0;
                    shown_duty[k] = '0;
                    pwr_en[k] = 1'b0;
                end
                dither_run = 1'b0;
                pulse = 1'b1;
            end
            default: ;
        endcase
        for (int k = 0; k < 3; k++) begin
            rs.duty[k] = shown_duty[k];
            rs.power[k] = pwr_en[k];
        end
        rs.counter_reset = pulse;
        rs.dither_on = dither_run;
        return rs;
    endfunction

    function automatic logic [LW-1:0] pick_level();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0: return '0;
            1: return LEVEL_MAX;
            2: return LW'($urandom_range(LEVEL_MAX + 1, LEVEL_TOP));
            3: return {DB'($urandom), FB'(0)};
            default: return LW'($urandom_range(0, LEVEL_TOP));
        endcase
    endfunction

    task automatic queue_req(input logic [1:0] op, input logic [LW-1:0] la,
                             input logic [LW-1:0] lb, input logic [LW-1:0] lc,
                             input logic [2:0] keep);
        led_cmd_t c;
        c.opcode = op;
        c.level[0] = la;
        c.level[1] = lb;
        c.level[2] = lc;
        c.keep_on = keep;
        pending_cmds.push_back(c);
        case (op)
            OP_TICK: n_tick++;
            OP_SET: begin
                n_set++;
                for (int k = 0; k < 3; k++) if (c.level[k] > LEVEL_MAX) n_sat++;
            end
            OP_OFF: n_off++;
            default: n_unused++;
        endcase
    endtask

    // Payload is ignored for everything but set, so fill it with noise
    task automatic queue_noise(input logic [1:0] op);
        queue_req(op, LW'($urandom), LW'($urandom), LW'($urandom), 3'($urandom));
    endtask

    // Random idling, except in calm stretches and near the end
    function automatic bit idle_allowed();
        return (reqs_issued < idle_stop) && (((reqs_issued / 100) % 4) != 3);
    endfunction

    // Request driver
    always @(posedge aclk) begin
        led_cmd_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                s_opcode  <= c.opcode;
                s_level_a <= c.level[0];
                s_level_b <= c.level[1];
                s_level_c <= c.level[2];
                s_force_a <= c.keep_on[0];
                s_force_b <= c.keep_on[1];
                s_force_c <= c.keep_on[2];
                s_valid   <= 1'b1;
                reqs_issued++;
                if (idle_allowed() && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 9);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Response back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_allowed() && $urandom_range(0, 7) == 0) sink_gap = $urandom_range(1, 9);
        end
    end

    // Monitor: predict on each accepted request, check each accepted response
    always @(posedge aclk) begin
        led_cmd_t c;
        led_frame_t want, got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                c.opcode = s_opcode;
                c.level[0] = s_level_a;
                c.level[1] = s_level_b;
                c.level[2] = s_level_c;
                c.keep_on = {s_force_c, s_force_b, s_force_a};
                due_frames.push_back(dither_step(c));
            end
            if (m_valid && m_ready) begin
                got.duty[0] = m_duty_a;
                got.duty[1] = m_duty_b;
                got.duty[2] = m_duty_c;
                got.power = {m_power_c, m_power_b, m_power_a};
                got.counter_reset = m_counter_reset;
                got.dither_on = m_dither_on;
                frames_checked++;
                if (due_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("response %0d arrived with nothing expected", frames_checked);
                end else begin
                    want = due_frames.pop_front();
                    if (got.duty !== want.duty || got.power !== want.power
                        || got.counter_reset !== want.counter_reset
                        || got.dither_on !== want.dither_on) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("response %0d: exp duty %0d/%0d/%0d pwr %b cr %b dith %b,",
                                   frames_checked, want.duty[0], want.duty[1], want.duty[2],
                                   want.power, want.counter_reset, want.dither_on);
                            $display(" got duty %0d/%0d/%0d pwr %b cr %b dith %b",
                                     got.duty[0], got.duty[1], got.duty[2],
                                     got.power, got.counter_reset, got.dither_on);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no progress for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int dir_count;
        int r;
        for (int k = 0; k < 3; k++) begin
            level_q[k] = '0;
            frac_acc[k] = '0;
            queued_duty[k] = '0;
            shown_duty[k] = '0;
            pwr_en[k] = 1'b0;
        end
        dither_run = 1'b0;

        // Directed: stopped ticks, unused code, zero/forced/full/oversized levels,
        // fractional dithering, off and restart with kept accumulators
        queue_noise(OP_TICK);
        queue_noise(OP_UNUSED);
        queue_req(OP_SET, '0, '0, '0, 3'b000);
        queue_noise(OP_TICK);
        queue_req(OP_SET, '0, '0, '0, 3'b111);
        queue_req(OP_SET, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX, 3'b000);
        queue_noise(OP_TICK);
        queue_noise(OP_TICK);
        queue_req(OP_SET, LEVEL_TOP, LW'(LEVEL_MAX + 1), LW'(16'h7FC0), 3'b101);
        queue_noise(OP_TICK);
        queue_req(OP_SET, LW'(16'h0040), LW'(16'h7F7F), LW'(16'h0001), 3'b010);
        repeat (6) queue_noise(OP_TICK);
        queue_noise(OP_UNUSED);
        queue_noise(OP_OFF);
        queue_noise(OP_TICK);
        queue_req(OP_SET, LW'(16'h2A55), LW'(16'h552A), LW'(16'h007F), 3'b000);
        queue_noise(OP_TICK);
        queue_noise(OP_TICK);
        queue_noise(OP_OFF);
        dir_count = pending_cmds.size();

        // Random: mostly set followed by tick runs, some off and unused codes
        while (pending_cmds.size() < dir_count + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                queue_req(OP_SET, pick_level(), pick_level(), pick_level(), 3'($urandom));
                repeat ($urandom_range(1, 16)) queue_noise(OP_TICK);
            end else if (r < 80) begin
                repeat ($urandom_range(1, 8)) queue_noise(OP_TICK);
            end else if (r < 93) begin
                queue_noise(OP_OFF);
            end else begin
                queue_noise(OP_UNUSED);
            end
        end
        idle_stop = pending_cmds.size() - CALM_TAIL;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain, then wait for any stray response
        @(posedge aclk);
        while (pending_cmds.size() > 0 || s_valid || due_frames.size() > 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("checked %0d responses: %0d set (%0d oversized levels), %0d tick (%0d dithering),",
                 frames_checked, n_set, n_sat, n_tick, n_live_tick);
        $display("%0d off, %0d unused opcode; %0d mismatches", n_off, n_unused, mismatches);
        if (mismatches == 0 && due_frames.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
design/dsmpwm_pkg.sv
design/dsmpwm_lane.sv
design/dsmpwm_merge.sv
design/three_channel_dsm_pwm_dither_top.sv
sim/testbench.sv
